FILE: rtl/core/bfpa_pkg.sv
// bfpa_pkg.sv: shared constants and types for the best-fit pool allocator
`timescale 1ns / 1ps

package bfpa_pkg;

    // pool geometry
    localparam int POOL_UNITS      = 256;
    localparam int UNIT_BYTES      = 16;
    localparam int MIN_BLOCK_UNITS = 3;
    localparam int HEADER_BYTES    = 24;

    // derived widths
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int UNIT_W     = $clog2(POOL_UNITS);
    localparam int COUNT_W    = UNIT_W + 1;

    // fixed field widths
    localparam int REQ_W      = 16;
    localparam int ADDR_W     = 12;
    localparam int USED_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int NEED_SUM_W = REQ_W + 1;
    localparam int NEED_W     = NEED_SUM_W - UNIT_SHIFT;

    // map entry: block start bit and allocated bit per unit
    localparam int ENTRY_W     = 2;
    localparam int ENTRY_START = 1;
    localparam int ENTRY_ALLOC = 0;

    // request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_ATAIL,
        S_ACOMMIT,
        S_ASPLIT,
        S_FUP,
        S_FDOWN,
        S_FWR1,
        S_FWR2,
        S_RESP
    } state_t;

endpackage

FILE: rtl/core/bfpa_ram.sv
// bfpa_ram.sv: generic single write port ram with registered read
`timescale 1ns / 1ps

module bfpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/best_fit_pool_allocator.sv
// best_fit_pool_allocator.sv: best-fit allocator with coalescing over a unit-granular pool
`timescale 1ns / 1ps

// channel   signals                                   dir  meaning
// req       req_valid req_ready func                  in   allocate or free transaction
//           request_bytes free_address
// rsp       rsp_valid rsp_ready status                out  one status per transaction
//
// an allocate reads the map ram one unit per cycle over the whole pool, then commits in one
// write, or in two writes on a split.
// a free walks up to the end of its block and back to the previous start, then writes once,
// twice when it joins the next block; a null or bad free goes straight to the response, a stale one after its check.
// after reset a clearing pass over all POOL_UNITS units rebuilds the map, req_ready stays low.
// a finished status waits in the rsp register while the next transaction is taken.

module best_fit_pool_allocator
    import bfpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                func,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   free_address,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status
);

    localparam logic [COUNT_W-1:0] LAST_IDX  = COUNT_W'(POOL_UNITS - 1);
    localparam logic [UNIT_W-1:0]  LAST_UNIT = UNIT_W'(POOL_UNITS - 1);
    localparam logic [COUNT_W-1:0] POOL_CNT  = COUNT_W'(POOL_UNITS);
    localparam int                 POOL_BYTES = POOL_UNITS * UNIT_BYTES;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [UNIT_W-1:0]    pend_unit_reg, pend_unit_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic [UNIT_W-1:0]    cur_start_reg, cur_start_next;
    logic                 cur_alloc_reg, cur_alloc_next;
    logic                 found_reg, found_next;
    logic [UNIT_W-1:0]    best_reg, best_next;
    logic [COUNT_W-1:0]   best_size_reg, best_size_next;
    logic [UNIT_W-1:0]    u_reg, u_next;
    logic [COUNT_W-1:0]   e_reg, e_next;
    logic                 join_next_reg, join_next_next;
    logic                 join_prev_reg, join_prev_next;
    logic [USED_W-1:0]    used_total_reg, used_total_next;
    status_t              result_reg, result_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              status_reg, status_next;

    logic                 ram_we;
    logic [UNIT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 rd_start;
    logic                 rd_alloc;

    logic [NEED_SUM_W-1:0] need_sum;
    logic [NEED_W-1:0]     need_raw;
    logic [NEED_W-1:0]     need_val;
    logic [ADDR_W-1:0]     addr_off;
    logic [ADDR_W-1:0]     free_unit_wide;
    logic                  free_bad;
    logic [COUNT_W-1:0]    blk_end;
    logic [COUNT_W-1:0]    blk_size;
    logic                  blk_fits;
    logic [COUNT_W-1:0]    rest_size;
    logic                  do_split;
    logic [COUNT_W-1:0]    free_size;

    // block map: start and allocated bit per unit
    bfpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_UNITS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[UNIT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ENTRY_START];
    assign rd_alloc = ram_rdata[ENTRY_ALLOC];

    // units needed for an allocate, with header and minimum block size
    assign need_sum = NEED_SUM_W'(request_bytes) + NEED_SUM_W'(HEADER_BYTES + UNIT_BYTES - 1);
    assign need_raw = need_sum[NEED_SUM_W-1:UNIT_SHIFT];
    assign need_val = (need_raw < NEED_W'(MIN_BLOCK_UNITS)) ? NEED_W'(MIN_BLOCK_UNITS)
                                                            : need_raw;

    // free address decode and range checks
    assign addr_off       = free_address - ADDR_W'(HEADER_BYTES);
    assign free_unit_wide = addr_off >> UNIT_SHIFT;
    assign free_bad       = (free_address < ADDR_W'(HEADER_BYTES))
                         || (addr_off[UNIT_SHIFT-1:0] != '0)
                         || (free_unit_wide >= POOL_UNITS);

    // shared block compare: closes the block that runs up to the current unit
    assign blk_end  = (state_reg == S_ATAIL) ? POOL_CNT : {1'b0, pend_unit_reg};
    assign blk_size = blk_end - {1'b0, cur_start_reg};
    assign blk_fits = !cur_alloc_reg
                   && (NEED_W'(blk_size) >= need_reg)
                   && (!found_reg || (blk_size < best_size_reg));

    // split decision for the chosen block
    assign rest_size = best_size_reg - COUNT_W'(need_reg);
    assign do_split  = rest_size >= COUNT_W'(MIN_BLOCK_UNITS);

    // size of the block being freed
    assign free_size = e_reg - {1'b0, u_reg};

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_unit_next  = idx_reg[UNIT_W-1:0];
        need_next       = need_reg;
        cur_start_next  = cur_start_reg;
        cur_alloc_next  = cur_alloc_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        u_next          = u_reg;
        e_next          = e_reg;
        join_next_next  = join_next_reg;
        join_prev_next  = join_prev_reg;
        used_total_next = used_total_reg;
        result_next     = result_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;

        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (func == FUNC_ALLOC)
                    begin
                        need_next  = need_val;
                        found_next = 1'b0;
                        idx_next   = '0;
                        state_next = S_ASCAN;
                    end
                    else if (free_address == '0)
                    begin
                        result_next = STAT_OK;
                        state_next  = S_RESP;
                    end
                    else if (free_bad)
                    begin
                        result_next = STAT_BAD_FREE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        u_next     = UNIT_W'(free_unit_wide);
                        idx_next   = {1'b0, UNIT_W'(free_unit_wide)};
                        state_next = S_FUP;
                    end
                end
            end

            // walk the map, closing one block at each start bit
            S_ASCAN:
            begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (pend_unit_reg == '0)
                    begin
                        cur_start_next = '0;
                        cur_alloc_next = rd_alloc;
                    end
                    else if (rd_start)
                    begin
                        if (blk_fits)
                        begin
                            found_next     = 1'b1;
                            best_next      = cur_start_reg;
                            best_size_next = blk_size;
                        end
                        cur_start_next = pend_unit_reg;
                        cur_alloc_next = rd_alloc;
                    end
                    if (pend_unit_reg == LAST_UNIT)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_ATAIL;
                    end
                end
            end

            // last block runs to the end of the pool
            S_ATAIL:
            begin
                if (blk_fits)
                begin
                    found_next     = 1'b1;
                    best_next      = cur_start_reg;
                    best_size_next = blk_size;
                end
                state_next = S_ACOMMIT;
            end

            S_ACOMMIT:
            begin
                if (!found_reg)
                begin
                    result_next = STAT_NO_SPACE;
                    state_next  = S_RESP;
                end
                else
                begin
                    result_next = STAT_OK;
                    if (do_split)
                    begin
                        used_total_next = used_total_reg
                                        + (USED_W'(need_reg) << UNIT_SHIFT);
                        state_next      = S_ASPLIT;
                    end
                    else
                    begin
                        used_total_next = used_total_reg
                                        + (USED_W'(best_size_reg) << UNIT_SHIFT);
                        state_next      = S_RESP;
                    end
                end
            end

            S_ASPLIT:
            begin
                state_next = S_RESP;
            end

            // check the block and find its end
            S_FUP:
            begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (pend_unit_reg == u_reg)
                    begin
                        if (!(rd_start && rd_alloc))
                        begin
                            pend_next   = 1'b0;
                            result_next = STAT_BAD_FREE;
                            state_next  = S_RESP;
                        end
                        else if (pend_unit_reg == LAST_UNIT)
                        begin
                            pend_next      = 1'b0;
                            e_next         = POOL_CNT;
                            join_next_next = 1'b0;
                            state_next     = S_FDOWN;
                        end
                    end
                    else if (rd_start)
                    begin
                        pend_next      = 1'b0;
                        e_next         = {1'b0, pend_unit_reg};
                        join_next_next = !rd_alloc;
                        state_next     = S_FDOWN;
                    end
                    else if (pend_unit_reg == LAST_UNIT)
                    begin
                        pend_next      = 1'b0;
                        e_next         = POOL_CNT;
                        join_next_next = 1'b0;
                        state_next     = S_FDOWN;
                    end

                    // leaving the upward walk: set up the backward walk
                    if (state_next == S_FDOWN)
                    begin
                        if (u_reg == '0)
                        begin
                            join_prev_next = 1'b0;
                            state_next     = S_FWR1;
                        end
                        else
                        begin
                            idx_next = {1'b0, u_reg} - 1'b1;
                        end
                    end
                end
            end

            // walk back to the previous block start
            S_FDOWN:
            begin
                idx_next  = idx_reg - 1'b1;
                pend_next = 1'b1;
                if (pend_reg && rd_start)
                begin
                    pend_next      = 1'b0;
                    join_prev_next = !rd_alloc;
                    state_next     = S_FWR1;
                end
            end

            S_FWR1:
            begin
                used_total_next = used_total_reg - (USED_W'(free_size) << UNIT_SHIFT);
                result_next     = STAT_OK;
                state_next      = join_next_reg ? S_FWR2 : S_RESP;
            end

            S_FWR2:
            begin
                state_next = S_RESP;
            end

            // hand the status to the response register once it is free
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = result_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and map writes
    always_comb
    begin
        req_ready = (state_reg == S_IDLE);
        ram_we    = 1'b0;
        ram_waddr = idx_reg[UNIT_W-1:0];
        ram_wdata = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = idx_reg[UNIT_W-1:0];
                ram_wdata[ENTRY_START] = (idx_reg == '0);
            end

            S_ACOMMIT:
            begin
                ram_we                 = found_reg;
                ram_waddr              = best_reg;
                ram_wdata[ENTRY_START] = 1'b1;
                ram_wdata[ENTRY_ALLOC] = 1'b1;
            end

            S_ASPLIT:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = UNIT_W'({1'b0, best_reg} + COUNT_W'(need_reg));
                ram_wdata[ENTRY_START] = 1'b1;
            end

            S_FWR1:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = u_reg;
                ram_wdata[ENTRY_START] = !join_prev_reg;
            end

            S_FWR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = e_reg[UNIT_W-1:0];
            end

            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            used_total_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            used_total_reg <= used_total_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pend_unit_reg <= pend_unit_next;
        need_reg      <= need_next;
        cur_start_reg <= cur_start_next;
        cur_alloc_reg <= cur_alloc_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        u_reg         <= u_next;
        e_reg         <= e_next;
        join_next_reg <= join_next_next;
        join_prev_reg <= join_prev_next;
        result_reg    <= result_next;
        status_reg    <= status_next;
    end

`ifndef SYNTHESIS
    // unit 0 always opens a block
    a_unit0_start: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ASCAN) && pend_reg && (pend_unit_reg == '0)) |-> rd_start)
        else $error("unit 0 lost its block start bit");

    // bytes in use never exceed the pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_total_reg <= USED_W'(POOL_BYTES))
        else $error("used byte count beyond pool size");

    // the chosen block holds the request
    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ACOMMIT) && found_reg) |-> (NEED_W'(best_size_reg) >= need_reg))
        else $error("chosen block smaller than request");

    // a response only appears from the response step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside the response step");
`endif

endmodule
